// ===== rtl/cssh_pkg.sv =====
package cssh_pkg;

  localparam int CLASS_COUNT = 7;
  localparam int TIME_BITS   = 32;
  localparam int CLASS_BITS  = $clog2(CLASS_COUNT);
  localparam int PROB_BITS   = 17;
  localparam int FRAC_BITS   = 16;
  localparam int HOLD_BITS   = 16;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 17;

  localparam int IN_RAW_BITS   = TIME_BITS + CLASS_COUNT * PROB_BITS;
  localparam int IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
  localparam int OUT_RAW_BITS  = CLASS_BITS + PROB_BITS + CLASS_COUNT * PROB_BITS;
  localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

  localparam logic [CLASS_BITS-1:0] NEUTRAL     = CLASS_BITS'(CLASS_COUNT - 1);
  localparam logic [PROB_BITS-1:0]  ONE_Q16     = PROB_BITS'(1 << FRAC_BITS);
  localparam logic [PROB_BITS-1:0]  ALPHA_RESET = PROB_BITS'(19661);
  localparam logic [HOLD_BITS-1:0]  HOLD_RESET  = HOLD_BITS'(500);

  localparam logic [CFG_IDX_BITS-1:0] REG_ALPHA = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_HOLD  = CFG_IDX_BITS'(1);

  // running argmax handed from cell to cell
  typedef struct packed {
    logic [PROB_BITS-1:0]  val;
    logic [CLASS_BITS-1:0] idx;
  } best_t;

  // one frame's summary as it enters the hold stage
  typedef struct packed {
    logic                 frame;
    best_t                best;
    logic [TIME_BITS-1:0] now;
  } frame_t;

endpackage

// ===== rtl/cssh_cell.sv =====
module cssh_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [cssh_pkg::CLASS_BITS-1:0] cell_idx,
  input  logic                            upd,
  input  logic                            load1,
  input  logic                            load2,
  input  logic [cssh_pkg::PROB_BITS-1:0]  alpha,
  input  logic [cssh_pkg::PROB_BITS-1:0]  alpha_inv,
  input  logic [cssh_pkg::PROB_BITS-1:0]  raw,
  input  cssh_pkg::best_t                 best_in,
  output cssh_pkg::best_t                 best_out,
  output logic [cssh_pkg::PROB_BITS-1:0]  smooth
);
  import cssh_pkg::*;

  logic [PROB_BITS-1:0]   s;
  logic [PROB_BITS-1:0]   p1_s;
  logic [PROB_BITS-1:0]   p2_s;
  logic [PROB_BITS-1:0]   raw_sat;
  logic [2*PROB_BITS-1:0] acc;
  logic [PROB_BITS-1:0]   s_new;

  assign raw_sat = (raw > ONE_Q16) ? ONE_Q16 : raw;
  // both terms together never exceed 2^32, so the shifted sum fits
  assign acc   = alpha * raw_sat + alpha_inv * s;
  assign s_new = acc[FRAC_BITS +: PROB_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      s <= (cell_idx == NEUTRAL) ? ONE_Q16 : '0;
    end else if (upd) begin
      s <= s_new;
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      p1_s <= upd ? s_new : s;
    end
    if (load2) begin
      p2_s <= p1_s;
    end
  end

  // strict compare keeps ties on the lower index
  always_comb begin
    best_out = best_in;
    if (p1_s > best_in.val) begin
      best_out.val = p1_s;
      best_out.idx = cell_idx;
    end
  end

  assign smooth = p2_s;

endmodule

// ===== rtl/cssh_hold.sv =====
module cssh_hold (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic                            upd,
  input  logic [cssh_pkg::HOLD_BITS-1:0]  hold_time,
  input  cssh_pkg::frame_t                info,
  output logic [cssh_pkg::CLASS_BITS-1:0] report,
  output logic [cssh_pkg::PROB_BITS-1:0]  conf
);
  import cssh_pkg::*;

  logic [CLASS_BITS-1:0] dominant;
  logic [TIME_BITS-1:0]  since;
  logic [CLASS_BITS-1:0] held;
  logic                  changed;
  logic [TIME_BITS-1:0]  since_next;
  logic [TIME_BITS-1:0]  elapsed;
  logic [CLASS_BITS-1:0] held_next;

  assign changed    = (info.best.idx != dominant);
  assign since_next = changed ? info.now : since;
  assign elapsed    = info.now - since_next;
  assign held_next  = (elapsed >= TIME_BITS'(hold_time)) ? info.best.idx : held;

  always_ff @(posedge clk) begin
    if (rst) begin
      dominant <= NEUTRAL;
      since    <= '0;
      held     <= NEUTRAL;
    end else if (upd && info.frame) begin
      dominant <= info.best.idx;
      since    <= since_next;
      held     <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      report <= info.frame ? held_next : NEUTRAL;
      conf   <= info.frame ? info.best.val : '0;
    end
  end

  a_invalid_neutral: assert property (@(posedge clk) disable iff (rst)
    (load && !info.frame) |=> (report == NEUTRAL && conf == '0))
    else $error("invalid frame did not report neutral");

  a_zero_hold: assert property (@(posedge clk) disable iff (rst)
    (upd && info.frame && hold_time == '0) |=> (held == $past(info.best.idx)))
    else $error("zero hold did not follow dominant class");

  a_dominant_tracks: assert property (@(posedge clk) disable iff (rst)
    (upd && info.frame) |=> (dominant == $past(info.best.idx)))
    else $error("dominant class not updated");

endmodule

// ===== rtl/class_score_smoother_with_hold_top.sv =====
// Pipeline: a word accepted on the input reaches m_tvalid/m_tdata through the
//   EMA cell stage, the argmax chain stage and the hold/output stage.
// Throughput: one word per cycle unless m_tready stalls the output; each EMA state updates as its frame is accepted.
// Reset (rst, synchronous, active high): class 6 smoothed value 1.0, others 0,
//   dominant and held class neutral, start time 0, alpha 19661, hold 500 ms,
//   pipeline empty.
module class_score_smoother_with_hold_top (
  input  logic                                clk,
  input  logic                                rst,
  // in: now_ms, raw_p0 .. raw_p6 (lowest bits first), zero pad
  input  logic [cssh_pkg::IN_DATA_BITS-1:0]   s_tdata,
  // in: frame_valid
  input  logic                                s_tuser,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // out: reported_class, confidence, smooth_p0 .. smooth_p6, zero pad
  output logic [cssh_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                cfg_we,
  input  logic [cssh_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [cssh_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import cssh_pkg::*;

  // config registers; alpha is stored saturated along with 1.0 - alpha
  logic [PROB_BITS-1:0] alpha;
  logic [PROB_BITS-1:0] alpha_inv;
  logic [HOLD_BITS-1:0] hold_time;
  logic [PROB_BITS-1:0] alpha_sat;

  assign alpha_sat = (cfg_data > ONE_Q16) ? ONE_Q16 : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha     <= ALPHA_RESET;
      alpha_inv <= ONE_Q16 - ALPHA_RESET;
      hold_time <= HOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALPHA: begin
          alpha     <= alpha_sat;
          alpha_inv <= ONE_Q16 - alpha_sat;
        end
        REG_HOLD: begin
          hold_time <= cfg_data[HOLD_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // pipeline occupancy; each stage moves when the one after it has room,
  // so bubbles collapse and input keeps flowing while the output word waits
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;
  logic accept;

  assign rdy3     = !v3 || m_tready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // stage 1/2 side info (frame flag and timestamp follow the word)
  logic                 p1_frame;
  logic [TIME_BITS-1:0] p1_now;
  frame_t               p2;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      p1_frame <= s_tuser;
      p1_now   <= s_tdata[TIME_BITS-1:0];
    end
  end

  // row of cells: each holds one class's EMA state and extends the argmax
  best_t                best_chain [CLASS_COUNT+1];
  logic [PROB_BITS-1:0] smooth     [CLASS_COUNT];
  logic [PROB_BITS-1:0] out_s      [CLASS_COUNT];

  assign best_chain[0] = '{val: '0, idx: '0};

  for (genvar g = 0; g < CLASS_COUNT; g++) begin : g_cell
    cssh_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_idx  (CLASS_BITS'(g)),
      .upd       (accept && s_tuser),
      .load1     (rdy1),
      .load2     (rdy2),
      .alpha     (alpha),
      .alpha_inv (alpha_inv),
      .raw       (s_tdata[TIME_BITS + g*PROB_BITS +: PROB_BITS]),
      .best_in   (best_chain[g]),
      .best_out  (best_chain[g+1]),
      .smooth    (smooth[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      p2.frame <= p1_frame;
      p2.best  <= best_chain[CLASS_COUNT];
      p2.now   <= p1_now;
    end
    if (rdy3) begin
      for (int i = 0; i < CLASS_COUNT; i++) begin
        out_s[i] <= smooth[i];
      end
    end
  end

  // dominant tracking, persistence hold and the reported class
  logic [CLASS_BITS-1:0] report;
  logic [PROB_BITS-1:0]  conf;

  cssh_hold u_hold (
    .clk       (clk),
    .rst       (rst),
    .load      (rdy3),
    .upd       (rdy3 && v2),
    .hold_time (hold_time),
    .info      (p2),
    .report    (report),
    .conf      (conf)
  );

  always_comb begin
    m_tdata = '0;
    m_tdata[CLASS_BITS-1:0]           = report;
    m_tdata[CLASS_BITS +: PROB_BITS]  = conf;
    for (int i = 0; i < CLASS_COUNT; i++) begin
      m_tdata[CLASS_BITS + PROB_BITS + i*PROB_BITS +: PROB_BITS] = out_s[i];
    end
  end

  a_ready_when_out_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  a_word_reaches_out: assert property (@(posedge clk) disable iff (rst)
    (v2 && rdy3) |=> m_tvalid)
    else $error("word lost between argmax and output stage");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("output word changed while stalled");

endmodule
